[design/ptti_pkg.sv]
// ----------------------------------------------------------------------------
// ptti_pkg
// Shared types and codes of the periodic trilinear table interpolator.
// ----------------------------------------------------------------------------
package ptti_pkg;

   // operation codes
   localparam logic [1:0] OP_AXIS  = 2'd0;
   localparam logic [1:0] OP_ENTRY = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // axis codes
   localparam logic [1:0] AX_SPEED   = 2'd0;
   localparam logic [1:0] AX_HEADING = 2'd1;
   localparam logic [1:0] AX_FREQ    = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_SPEED_POINTS   = 3'd0;
   localparam logic [2:0] CSR_HEADING_POINTS = 3'd1;
   localparam logic [2:0] CSR_FREQ_POINTS    = 3'd2;
   localparam logic [2:0] CSR_MODE_COUNT     = 3'd3;
   localparam int         CSR_DW             = 7;

   // coordinate datapath width, full turn of 360 degrees in Q16.16
   localparam int                   XW        = 36;
   localparam int                   DW        = 36;
   localparam logic signed [XW-1:0] FULL_TURN = 36'sd23592960;
   localparam logic [16:0]          ONE_Q16   = 17'd65536;

   // axis read address select
   localparam logic [1:0] RA_FIRST = 2'd0;
   localparam logic [1:0] RA_LAST  = 2'd1;
   localparam logic [1:0] RA_SCAN  = 2'd2;

   // bracket result commands
   localparam logic [2:0] RES_NONE      = 3'd0;
   localparam logic [2:0] RES_LOW       = 3'd1;
   localparam logic [2:0] RES_HIGH      = 3'd2;
   localparam logic [2:0] RES_WRAP_FULL = 3'd3;
   localparam logic [2:0] RES_DIV_SCAN  = 3'd4;
   localparam logic [2:0] RES_DIV_WRAP  = 3'd5;
   localparam logic [2:0] RES_DIV_END   = 3'd6;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         axis_sel;
      logic [2:0]         speed_index;
      logic [5:0]         heading_index;
      logic [5:0]         freq_index;
      logic [2:0]         mode_index;
      logic signed [31:0] axis_value;
      logic signed [31:0] entry_re;
      logic signed [31:0] entry_im;
      logic signed [31:0] query_speed;
      logic signed [31:0] query_heading;
      logic signed [31:0] query_freq;
   } req_type;

   typedef struct packed {
      logic [2:0]         mode_out;
      logic signed [31:0] value_re;
      logic signed [31:0] value_im;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] axis;
      logic       x_load;
      logic       mod_step;
      logic       ax_rd;
      logic [1:0] ax_addr;
      logic       cap_first;
      logic       cap_last;
      logic       h_adjust;
      logic       scan_init;
      logic       scan_next;
      logic [2:0] result;
      logic       div_step;
      logic       mode_init;
      logic       mode_next;
      logic       tab_rd;
      logic       lerp_a;
      logic       lerp_b;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic wrap_over;
      logic wrap_full;
      logic at_low;
      logic at_high;
      logic scan_hit;
      logic div_done;
      logic lerp_done;
      logic corner_done;
      logic mode_last;
   } sts_type;

endpackage

[design/ptti_ctrl.sv]
// ----------------------------------------------------------------------------
// ptti_ctrl
// Sequencer: axis search, heading reduction, divide, corner reads, blends.
// ----------------------------------------------------------------------------
module ptti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_op,
   output logic              busy,
   output ptti_pkg::cmd_type cmd,
   input  ptti_pkg::sts_type sts
);
   import ptti_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_XLOAD = 5'd1;
   localparam logic [4:0] S_MOD   = 5'd2;
   localparam logic [4:0] S_RD0   = 5'd3;
   localparam logic [4:0] S_RDL   = 5'd4;
   localparam logic [4:0] S_CHK   = 5'd5;
   localparam logic [4:0] S_HADJ  = 5'd6;
   localparam logic [4:0] S_DEC   = 5'd7;
   localparam logic [4:0] S_SCRD  = 5'd8;
   localparam logic [4:0] S_SCCK  = 5'd9;
   localparam logic [4:0] S_DIV   = 5'd10;
   localparam logic [4:0] S_DEND  = 5'd11;
   localparam logic [4:0] S_TR    = 5'd12;
   localparam logic [4:0] S_TW    = 5'd13;
   localparam logic [4:0] S_LA    = 5'd14;
   localparam logic [4:0] S_LB    = 5'd15;
   localparam logic [4:0] S_OUT   = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= AX_SPEED;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      advance  = 1'b0;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = start;
            if (start && req_op == OP_QUERY) begin
               axis_in  = AX_SPEED;
               state_in = S_XLOAD;
            end
         end
         S_XLOAD: begin
            cmd.x_load = 1'b1;
            state_in   = (axis_ff == AX_HEADING) ? S_MOD : S_RD0;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) state_in = S_RD0;
         end
         S_RD0: begin
            cmd.ax_rd   = 1'b1;
            cmd.ax_addr = RA_FIRST;
            state_in    = S_RDL;
         end
         S_RDL: begin
            cmd.ax_rd     = 1'b1;
            cmd.ax_addr   = RA_LAST;
            cmd.cap_first = 1'b1;
            state_in      = S_CHK;
         end
         S_CHK: begin
            cmd.cap_last = 1'b1;
            state_in     = (axis_ff == AX_HEADING) ? S_HADJ : S_DEC;
         end
         S_HADJ: begin
            cmd.h_adjust = 1'b1;
            state_in     = S_DEC;
         end
         S_DEC: begin
            if (axis_ff == AX_HEADING && sts.wrap_over) begin
               if (sts.wrap_full) begin
                  cmd.result = RES_WRAP_FULL;
                  advance    = 1'b1;
               end else begin
                  cmd.result = RES_DIV_WRAP;
                  state_in   = S_DIV;
               end
            end else if (sts.at_low) begin
               cmd.result = RES_LOW;
               advance    = 1'b1;
            end else if (sts.at_high) begin
               cmd.result = RES_HIGH;
               advance    = 1'b1;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCRD;
            end
         end
         S_SCRD: begin
            cmd.ax_rd   = 1'b1;
            cmd.ax_addr = RA_SCAN;
            state_in    = S_SCCK;
         end
         S_SCCK: begin
            if (sts.scan_hit) begin
               cmd.result = RES_DIV_SCAN;
               state_in   = S_DIV;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCRD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_DEND;
         end
         S_DEND: begin
            cmd.result = RES_DIV_END;
            advance    = 1'b1;
         end
         S_TR: begin
            cmd.tab_rd = 1'b1;
            if (sts.corner_done) state_in = S_TW;
         end
         S_TW: state_in = S_LA;
         S_LA: begin
            cmd.lerp_a = 1'b1;
            state_in   = S_LB;
         end
         S_LB: begin
            cmd.lerp_b = 1'b1;
            state_in   = sts.lerp_done ? S_OUT : S_LA;
         end
         S_OUT: begin
            cmd.emit = 1'b1;
            if (sts.mode_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.mode_next = 1'b1;
               state_in      = S_TR;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // axis finished: next axis or start the mode loop
      if (advance) begin
         if (axis_ff == AX_FREQ) begin
            cmd.mode_init = 1'b1;
            state_in      = S_TR;
         end else begin
            axis_in  = axis_ff + 2'd1;
            state_in = S_XLOAD;
         end
      end
   end

endmodule

[design/ptti_dpath.sv]
// ----------------------------------------------------------------------------
// ptti_dpath
// Axis and table storage, coordinate unit, divider and blend unit.
// ----------------------------------------------------------------------------
module ptti_dpath #(
   parameter int MAX_SPEED_POINTS   = 8,
   parameter int MAX_HEADING_POINTS = 64,
   parameter int MAX_FREQ_POINTS    = 64,
   parameter int MAX_MODES          = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptti_pkg::req_type           req_item,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [ptti_pkg::CSR_DW-1:0] csr_wdata,
   input  ptti_pkg::cmd_type           cmd,
   output ptti_pkg::sts_type           sts,
   output logic                        rsp_valid,
   output ptti_pkg::rsp_type           rsp_item
);
   import ptti_pkg::*;

   localparam int SPW   = $clog2(MAX_SPEED_POINTS);
   localparam int HPW   = $clog2(MAX_HEADING_POINTS);
   localparam int FPW   = $clog2(MAX_FREQ_POINTS);
   localparam int MPW   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int MAXHF = (MAX_HEADING_POINTS > MAX_FREQ_POINTS) ?
                          MAX_HEADING_POINTS : MAX_FREQ_POINTS;
   localparam int MAXAX = (MAXHF > MAX_SPEED_POINTS) ? MAXHF : MAX_SPEED_POINTS;
   localparam int AXW   = $clog2(MAXAX);
   localparam int NW    = $clog2(MAXAX + 1);
   localparam int NMW   = $clog2(MAX_MODES + 1);
   localparam int TAW   = SPW + HPW + FPW + MPW;

   // configuration
   logic [3:0] sp_ff, mc_ff;
   logic [6:0] hp_ff, fp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= 4'd2;
         hp_ff <= 7'd2;
         fp_ff <= 7'd2;
         mc_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_POINTS:   sp_ff <= csr_wdata[3:0];
            CSR_HEADING_POINTS: hp_ff <= csr_wdata[6:0];
            CSR_FREQ_POINTS:    fp_ff <= csr_wdata[6:0];
            CSR_MODE_COUNT:     mc_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   logic [31:0] sp_raw, hp_raw, fp_raw, mc_raw, sp_cl, hp_cl, fp_cl, mc_cl;
   logic [NW-1:0]  n_cur;
   logic [NMW-1:0] nm;

   always_comb begin
      sp_raw = 32'(sp_ff);
      hp_raw = 32'(hp_ff);
      fp_raw = 32'(fp_ff);
      mc_raw = 32'(mc_ff);
      sp_cl  = (sp_raw < 32'd2) ? 32'd2 :
               (sp_raw > 32'(MAX_SPEED_POINTS)) ? 32'(MAX_SPEED_POINTS) : sp_raw;
      hp_cl  = (hp_raw < 32'd2) ? 32'd2 :
               (hp_raw > 32'(MAX_HEADING_POINTS)) ? 32'(MAX_HEADING_POINTS) : hp_raw;
      fp_cl  = (fp_raw < 32'd2) ? 32'd2 :
               (fp_raw > 32'(MAX_FREQ_POINTS)) ? 32'(MAX_FREQ_POINTS) : fp_raw;
      mc_cl  = (mc_raw < 32'd1) ? 32'd1 :
               (mc_raw > 32'(MAX_MODES)) ? 32'(MAX_MODES) : mc_raw;
      nm     = NMW'(mc_cl);
      case (cmd.axis)
         AX_SPEED:   n_cur = NW'(sp_cl);
         AX_HEADING: n_cur = NW'(hp_cl);
         default:    n_cur = NW'(fp_cl);
      endcase
   end

   // write positions, widened for range checks
   logic [31:0] si_w, hi_w, fi_w, mi_w;
   logic        si_ok, hi_ok, fi_ok, mi_ok;

   always_comb begin
      si_w  = 32'(req_item.speed_index);
      hi_w  = 32'(req_item.heading_index);
      fi_w  = 32'(req_item.freq_index);
      mi_w  = 32'(req_item.mode_index);
      si_ok = si_w < 32'(MAX_SPEED_POINTS);
      hi_ok = hi_w < 32'(MAX_HEADING_POINTS);
      fi_ok = fi_w < 32'(MAX_FREQ_POINTS);
      mi_ok = mi_w < 32'(MAX_MODES);
   end

   logic ax_wr;
   assign ax_wr = cmd.accept && (req_item.op == OP_AXIS);

   // axis memories
   logic signed [31:0] spd_mem [MAX_SPEED_POINTS];
   logic signed [31:0] hdg_mem [MAX_HEADING_POINTS];
   logic signed [31:0] frq_mem [MAX_FREQ_POINTS];
   logic signed [31:0] spd_q_ff, hdg_q_ff, frq_q_ff;
   logic [AXW-1:0]     ra;
   logic [AXW-1:0]     i_ff, i_in;

   always_comb begin
      case (cmd.ax_addr)
         RA_FIRST: ra = '0;
         RA_LAST:  ra = AXW'(n_cur - NW'(1));
         default:  ra = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ax_wr && req_item.axis_sel == AX_SPEED && si_ok)
         spd_mem[si_w[SPW-1:0]] <= req_item.axis_value;
      if (cmd.ax_rd) spd_q_ff <= spd_mem[ra[SPW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ax_wr && req_item.axis_sel == AX_HEADING && hi_ok)
         hdg_mem[hi_w[HPW-1:0]] <= req_item.axis_value;
      if (cmd.ax_rd) hdg_q_ff <= hdg_mem[ra[HPW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ax_wr && req_item.axis_sel == AX_FREQ && fi_ok)
         frq_mem[fi_w[FPW-1:0]] <= req_item.axis_value;
      if (cmd.ax_rd) frq_q_ff <= frq_mem[ra[FPW-1:0]];
   end

   logic signed [31:0]   rd32;
   logic signed [XW-1:0] rd_val;

   always_comb begin
      case (cmd.axis)
         AX_SPEED:   rd32 = spd_q_ff;
         AX_HEADING: rd32 = hdg_q_ff;
         default:    rd32 = frq_q_ff;
      endcase
      rd_val = {{(XW-32){rd32[31]}}, rd32};
   end

   // latched query
   req_type q_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) q_ff <= req_item;
   end

   // coordinate and bracket search
   logic signed [XW-1:0] x_ff, x_in, a0_ff, al_ff, prev_ff, prev_in;
   logic signed [XW-1:0] turn_k, wnum, wden;
   logic [2:0]           k_ff, k_in;

   always_comb begin
      turn_k = FULL_TURN <<< k_ff;
      wnum   = x_ff - al_ff;
      wden   = a0_ff + FULL_TURN - al_ff;
      x_in   = x_ff;
      k_in   = k_ff;
      if (cmd.x_load) begin
         k_in = 3'd7;
         case (cmd.axis)
            AX_SPEED:   x_in = {{(XW-32){q_ff.query_speed[31]}}, q_ff.query_speed};
            // bias by 128 turns so the value is positive before reduction
            AX_HEADING: x_in = {{(XW-32){q_ff.query_heading[31]}}, q_ff.query_heading}
                               + (FULL_TURN <<< 7);
            default:    x_in = {{(XW-32){q_ff.query_freq[31]}}, q_ff.query_freq};
         endcase
      end else if (cmd.mod_step) begin
         if (x_ff >= turn_k) x_in = x_ff - turn_k;
         k_in = k_ff - 3'd1;
      end else if (cmd.h_adjust) begin
         if (x_ff < a0_ff) x_in = x_ff + FULL_TURN;
      end
      i_in    = i_ff;
      prev_in = prev_ff;
      if (cmd.scan_init) begin
         i_in    = AXW'(1);
         prev_in = a0_ff;
      end else if (cmd.scan_next) begin
         i_in    = i_ff + AXW'(1);
         prev_in = rd_val;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      prev_ff <= prev_in;
      if (cmd.cap_first) a0_ff <= rd_val;
      if (cmd.cap_last)  al_ff <= rd_val;
   end

   // bracket results and restoring divider
   logic [AXW-1:0] idx0_ff [3];
   logic [AXW-1:0] idx1_ff [3];
   logic [16:0]    w_ff    [3];
   logic [DW-1:0]  r_ff, dd_ff;
   logic [DW:0]    r2;
   logic [15:0]    qt_ff;
   logic [3:0]     dc_ff;

   assign r2 = {r_ff, 1'b0};

   always_ff @(posedge clock) begin
      case (cmd.result)
         RES_LOW: begin
            idx0_ff[cmd.axis] <= '0;
            idx1_ff[cmd.axis] <= AXW'(1);
            w_ff[cmd.axis]    <= '0;
         end
         RES_HIGH: begin
            idx0_ff[cmd.axis] <= AXW'(n_cur - NW'(2));
            idx1_ff[cmd.axis] <= AXW'(n_cur - NW'(1));
            w_ff[cmd.axis]    <= ONE_Q16;
         end
         RES_WRAP_FULL: begin
            idx0_ff[cmd.axis] <= AXW'(n_cur - NW'(1));
            idx1_ff[cmd.axis] <= '0;
            w_ff[cmd.axis]    <= ONE_Q16;
         end
         RES_DIV_SCAN: begin
            idx0_ff[cmd.axis] <= i_ff - AXW'(1);
            idx1_ff[cmd.axis] <= i_ff;
            r_ff              <= DW'(x_ff - prev_ff);
            dd_ff             <= DW'(rd_val - prev_ff);
            qt_ff             <= '0;
            dc_ff             <= '0;
         end
         RES_DIV_WRAP: begin
            idx0_ff[cmd.axis] <= AXW'(n_cur - NW'(1));
            idx1_ff[cmd.axis] <= '0;
            r_ff              <= DW'(wnum);
            dd_ff             <= DW'(wden);
            qt_ff             <= '0;
            dc_ff             <= '0;
         end
         RES_DIV_END: w_ff[cmd.axis] <= {1'b0, qt_ff};
         default: ;
      endcase
      if (cmd.div_step) begin
         if (r2 >= {1'b0, dd_ff}) begin
            r_ff  <= DW'(r2 - {1'b0, dd_ff});
            qt_ff <= {qt_ff[14:0], 1'b1};
         end else begin
            r_ff  <= r2[DW-1:0];
            qt_ff <= {qt_ff[14:0], 1'b0};
         end
         dc_ff <= dc_ff + 4'd1;
      end
   end

   // response table
   logic [63:0]    tab_mem [2**TAW];
   logic [63:0]    tab_q_ff;
   logic           tab_v_ff;
   logic [TAW-1:0] tab_wa, tab_ra;
   logic [AXW-1:0] cs, ch, cf;
   logic [MPW-1:0] m_ff;
   logic [2:0]     c_ff;

   always_comb begin
      tab_wa = {si_w[SPW-1:0], hi_w[HPW-1:0], fi_w[FPW-1:0], mi_w[MPW-1:0]};
      cs     = c_ff[0] ? idx1_ff[0] : idx0_ff[0];
      ch     = c_ff[1] ? idx1_ff[1] : idx0_ff[1];
      cf     = c_ff[2] ? idx1_ff[2] : idx0_ff[2];
      tab_ra = {cs[SPW-1:0], ch[HPW-1:0], cf[FPW-1:0], m_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_item.op == OP_ENTRY && si_ok && hi_ok && fi_ok && mi_ok)
         tab_mem[tab_wa] <= {req_item.entry_re, req_item.entry_im};
      if (cmd.tab_rd) tab_q_ff <= tab_mem[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) tab_v_ff <= 1'b0;
      else       tab_v_ff <= cmd.tab_rd;
   end

   // corner queue and blend unit
   logic [63:0]        qv_ff [8];
   logic [3:0]         qc_ff;
   logic [2:0]         lc_ff;
   logic [16:0]        wl, om;
   logic signed [17:0] wl_s, om_s;
   logic signed [31:0] re0, im0, re1, im1;
   logic signed [49:0] pa_re_ff, pa_im_ff;
   logic signed [50:0] t_re, t_im;
   logic [3:0]         qdst;

   always_comb begin
      wl   = (lc_ff < 3'd4) ? w_ff[0] : (lc_ff < 3'd6) ? w_ff[1] : w_ff[2];
      om   = ONE_Q16 - wl;
      wl_s = {1'b0, wl};
      om_s = {1'b0, om};
      re0  = qv_ff[0][63:32];
      im0  = qv_ff[0][31:0];
      re1  = qv_ff[1][63:32];
      im1  = qv_ff[1][31:0];
      t_re = 51'(pa_re_ff) + 51'(re1 * wl_s) + 51'sd32768;
      t_im = 51'(pa_im_ff) + 51'(im1 * wl_s) + 51'sd32768;
      qdst = qc_ff - 4'd2;
   end

   always_ff @(posedge clock) begin
      if (cmd.mode_init) m_ff <= '0;
      else if (cmd.mode_next) m_ff <= m_ff + MPW'(1);
      if (cmd.mode_init || cmd.mode_next) begin
         c_ff  <= '0;
         qc_ff <= '0;
         lc_ff <= '0;
      end else begin
         if (cmd.tab_rd) c_ff <= c_ff + 3'd1;
         if (tab_v_ff) begin
            qv_ff[qc_ff[2:0]] <= tab_q_ff;
            qc_ff             <= qc_ff + 4'd1;
         end
         if (cmd.lerp_a) begin
            pa_re_ff <= re0 * om_s;
            pa_im_ff <= im0 * om_s;
         end
         if (cmd.lerp_b) begin
            for (int j = 0; j < 6; j++) qv_ff[j] <= qv_ff[j+2];
            qv_ff[qdst[2:0]] <= {t_re[47:16], t_im[47:16]};
            qc_ff            <= qc_ff - 4'd1;
            lc_ff            <= lc_ff + 3'd1;
         end
      end
   end

   // result register
   logic mode_last;
   assign mode_last = (32'(m_ff) == 32'(nm) - 32'd1);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cmd.emit;
      if (cmd.emit) begin
         rsp_item.mode_out <= 3'(m_ff);
         rsp_item.value_re <= qv_ff[0][63:32];
         rsp_item.value_im <= qv_ff[0][31:0];
         rsp_item.last     <= mode_last;
      end
   end

   always_comb begin
      sts.mod_done    = (k_ff == 3'd0);
      sts.wrap_over   = (x_ff > al_ff);
      sts.wrap_full   = (wden <= 0) || (wnum >= wden);
      sts.at_low      = (x_ff <= a0_ff);
      sts.at_high     = (x_ff >= al_ff);
      sts.scan_hit    = (rd_val > x_ff) || (i_ff == AXW'(n_cur - NW'(1)));
      sts.div_done    = (dc_ff == 4'd15);
      sts.lerp_done   = (lc_ff == 3'd6);
      sts.corner_done = (c_ff == 3'd7);
      sts.mode_last   = mode_last;
   end

endmodule

[design/periodic_trilinear_table_interp.sv]
// ----------------------------------------------------------------------------
// periodic_trilinear_table_interp
// Trilinear lookup over speed, periodic heading and frequency axes.
// ----------------------------------------------------------------------------
// Axis and table writes are done in the transfer cycle; busy stays low.
// Query: per axis, read the first and last entries, scan entries as needed and
//   run the shared serial divider; heading adds modulo-360 reduction.
// Per mode: 8 table reads (one port, registered), blends one at a time in
//   the blend unit, then the output register is written for the result.
// Reset clears control and loads the point counts 2,2,2 and one mode;
//   axes and table hold no reset and must be written before use.
module periodic_trilinear_table_interp #(
   parameter int MAX_SPEED_POINTS   = 8,
   parameter int MAX_HEADING_POINTS = 64,
   parameter int MAX_FREQ_POINTS    = 64,
   parameter int MAX_MODES          = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ptti_pkg::req_type           req_item,
   output logic                        rsp_valid,
   output ptti_pkg::rsp_type           rsp_item,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [ptti_pkg::CSR_DW-1:0] csr_wdata
);
   import ptti_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: one transfer at a time
   ptti_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_item.op),
      .busy   (busy),
      .cmd    (cmd),
      .sts    (sts)
   );

   // storage, search, divide and blend
   ptti_dpath #(
      .MAX_SPEED_POINTS   (MAX_SPEED_POINTS),
      .MAX_HEADING_POINTS (MAX_HEADING_POINTS),
      .MAX_FREQ_POINTS    (MAX_FREQ_POINTS),
      .MAX_MODES          (MAX_MODES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef ASSERT_OFF
   // results other than the final one come while the query is still running
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> busy)
      else $error("non-final result outside a query");

   // results are never back to back
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in consecutive cycles");

   // a query transfer makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.op == OP_QUERY |=> busy)
      else $error("query accepted but block not busy");

   // writes complete in the transfer cycle
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.op != OP_QUERY |=> !busy)
      else $error("write left block busy");
`endif

endmodule
